// ===== rtl/nvrp_pkg.sv =====
// shared constants and helpers for the name/value record parser
package nvrp_pkg;

	localparam int NAME_DEPTH_DEF  = 16;
	localparam int FRAC_DIGITS_DEF = 8;

	localparam int CHAR_W  = 8;
	localparam int INT_W   = 32;
	localparam int QFRAC_W = 24;
	localparam int VALUE_W = INT_W + QFRAC_W;

	localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2f;
	localparam logic [CHAR_W-1:0] CH_COLON = 8'h3a;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0a;
	localparam logic [CHAR_W-1:0] CH_POINT = 8'h2e;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

	// powers of ten up to the largest fraction digit count
	function automatic logic [31:0] pow10(input logic [3:0] n);
		logic [31:0] p;
		case (n)
			4'd0: p = 32'd1;
			4'd1: p = 32'd10;
			4'd2: p = 32'd100;
			4'd3: p = 32'd1000;
			4'd4: p = 32'd10000;
			4'd5: p = 32'd100000;
			4'd6: p = 32'd1000000;
			4'd7: p = 32'd10000000;
			4'd8: p = 32'd100000000;
			default: p = 32'd1;
		endcase
		return p;
	endfunction

endpackage

// ===== rtl/name_value_record_parser_core.sv =====
// top level of the name/value record parser
//
// usage: one text byte enters per beat on text_valid/text_ready and is parsed
// as records of the form /name:value: . name characters go into a small
// synchronous ram, value digits are folded into an integer and a decimal
// fraction as they arrive. a byte that does not end a record leaves
// text_ready high, so ordinary bytes stream at one per cycle.
// the closing colon of a value starts the record end: a bit-serial divider
// turns the decimal fraction into 24 fraction bits, then the name is read
// back from the ram one character per beat (read, then load the output
// register), and an empty name still gives one beat. text_ready is low
// during the whole record end. the last beat of the run carries the value,
// the real flag, the truncation flag and last.
// results leave through a single output register on result_valid/
// result_ready; a stalled receiver holds the run where it is, and the next
// byte is taken while the final beat still waits in the register.
// reset puts the parser in idle mode, waiting for a slash, with an empty
// record; the name ram is not cleared since only written entries are read.
module name_value_record_parser_core #(
	parameter int NAME_DEPTH  = nvrp_pkg::NAME_DEPTH_DEF,
	parameter int FRAC_DIGITS = nvrp_pkg::FRAC_DIGITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         text_valid,
	output logic                         text_ready,
	input  logic [nvrp_pkg::CHAR_W-1:0]  text_byte,
	output logic                         result_valid,
	input  logic                         result_ready,
	output logic [nvrp_pkg::CHAR_W-1:0]  name_char,
	output logic                         name_char_valid,
	output logic [nvrp_pkg::VALUE_W-1:0] parsed_value,
	output logic                         is_real,
	output logic                         name_truncated,
	output logic                         last
);

	localparam int AW     = (NAME_DEPTH > 1) ? $clog2(NAME_DEPTH) : 1;
	localparam int LW     = $clog2(NAME_DEPTH + 1);
	localparam int DIV_W  = $clog2(nvrp_pkg::pow10(4'(FRAC_DIGITS)) + 1);
	localparam int FRAC_W = $clog2(nvrp_pkg::pow10(4'(FRAC_DIGITS)));
	localparam int FCW    = $clog2(FRAC_DIGITS + 1);
	localparam int INT_W  = nvrp_pkg::INT_W;
	localparam int QW     = nvrp_pkg::QFRAC_W;
	localparam int CW     = nvrp_pkg::CHAR_W;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_NAME,
		MODE_VALUE
	} mode_t;

	typedef enum logic [1:0] {
		ST_IN,
		ST_DIV,
		ST_RD,
		ST_WR
	} state_t;

	state_t            state_q;
	mode_t             mode_q;
	logic [LW-1:0]     name_len_q;
	logic              ovf_q;
	logic [INT_W-1:0]  int_q;
	logic [FRAC_W-1:0] frac_q;
	logic [FCW-1:0]    fdig_q;
	logic              point_q;
	logic [LW-1:0]     rd_idx_q;
	logic [QW-1:0]     qfrac_q;

	logic              out_valid_q;
	logic [CW-1:0]     out_char_q;
	logic              out_cvalid_q;
	logic [nvrp_pkg::VALUE_W-1:0] out_value_q;
	logic              out_real_q;
	logic              out_trunc_q;
	logic              out_last_q;

	logic              in_fire;
	logic              is_digit;
	logic [3:0]        digit;
	logic              name_wr;
	logic              rec_end;
	logic              load_ok;
	logic              run_last;
	logic [CW-1:0]     ram_rdata;
	logic              div_done;
	logic [QW-1:0]     div_quo;
	logic [DIV_W-1:0]  div_dsr;
	logic [INT_W-1:0]  int_next;
	logic [FRAC_W+3:0] frac_next;
	logic [nvrp_pkg::VALUE_W-1:0] rec_value;

	assign text_ready = (state_q == ST_IN);
	assign in_fire    = text_valid && text_ready;
	assign is_digit   = (text_byte >= nvrp_pkg::CH_ZERO) && (text_byte <= nvrp_pkg::CH_NINE);
	// '0'..'9' carry the digit in the low nibble
	assign digit      = text_byte[3:0];

	// name characters past capacity are dropped
	assign name_wr = in_fire && (mode_q == MODE_NAME)
		&& (text_byte != nvrp_pkg::CH_SLASH) && (text_byte != nvrp_pkg::CH_COLON)
		&& (text_byte != nvrp_pkg::CH_LF) && (name_len_q < LW'(NAME_DEPTH));
	assign rec_end = in_fire && (mode_q == MODE_VALUE) && (text_byte == nvrp_pkg::CH_COLON);

	// times ten as two shifts and an add, wrapping at 32 bits
	assign int_next  = (int_q << 3) + (int_q << 1) + INT_W'(digit);
	assign frac_next = ((FRAC_W + 4)'(frac_q) << 3) + ((FRAC_W + 4)'(frac_q) << 1)
		+ (FRAC_W + 4)'(digit);

	assign div_dsr = DIV_W'(nvrp_pkg::pow10(4'(fdig_q)));

	// integer sits in the low bits, or above the 24 fraction bits once a point was seen
	assign rec_value = point_q ? {int_q, qfrac_q}
		: {{(nvrp_pkg::VALUE_W - INT_W){1'b0}}, int_q};

	assign load_ok  = !out_valid_q || result_ready;
	assign run_last = (name_len_q == '0) || (rd_idx_q + LW'(1) == name_len_q);

	nvrp_ram #(
		.WIDTH (CW),
		.DEPTH (NAME_DEPTH)
	) u_name_ram (
		.clk   (clk),
		.we    (name_wr),
		.waddr (name_len_q[AW-1:0]),
		.wdata (text_byte),
		.raddr (rd_idx_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	nvrp_frac_div #(
		.DIV_W (DIV_W),
		.Q_W   (QW)
	) u_frac_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rec_end),
		.dividend (DIV_W'(frac_q)),
		.divisor  (div_dsr),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IN;
			mode_q       <= MODE_IDLE;
			name_len_q   <= '0;
			ovf_q        <= 1'b0;
			int_q        <= '0;
			frac_q       <= '0;
			fdig_q       <= '0;
			point_q      <= 1'b0;
			rd_idx_q     <= '0;
			qfrac_q      <= '0;
			out_valid_q  <= 1'b0;
			out_char_q   <= '0;
			out_cvalid_q <= 1'b0;
			out_value_q  <= '0;
			out_real_q   <= 1'b0;
			out_trunc_q  <= 1'b0;
			out_last_q   <= 1'b0;
		end else begin
			// a beat is loaded, or the waiting one stays until taken
			out_valid_q <= ((state_q == ST_WR) && load_ok) || (out_valid_q && !result_ready);
			case (state_q)
				ST_IN: begin
					if (in_fire) begin
						if (text_byte == nvrp_pkg::CH_SLASH) begin
							mode_q <= MODE_NAME;
						end else if (text_byte == nvrp_pkg::CH_COLON) begin
							if (mode_q == MODE_VALUE) begin
								state_q <= ST_DIV;
							end else if (mode_q == MODE_NAME) begin
								mode_q <= MODE_VALUE;
							end
						end else if (text_byte == nvrp_pkg::CH_LF) begin
							mode_q <= MODE_IDLE;
						end else if (mode_q == MODE_NAME) begin
							if (name_wr) begin
								name_len_q <= name_len_q + 1'b1;
							end else begin
								ovf_q <= 1'b1;
							end
						end else if (mode_q == MODE_VALUE) begin
							if (text_byte == nvrp_pkg::CH_POINT) begin
								point_q <= 1'b1;
							end else if (is_digit) begin
								if (!point_q) begin
									int_q <= int_next;
								end else if (fdig_q < FCW'(FRAC_DIGITS)) begin
									frac_q <= frac_next[FRAC_W-1:0];
									fdig_q <= fdig_q + 1'b1;
								end
							end
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						qfrac_q  <= div_quo;
						rd_idx_q <= '0;
						state_q  <= ST_RD;
					end
				end
				ST_RD: begin
					// ram read issued this cycle, data arrives next
					state_q <= ST_WR;
				end
				ST_WR: begin
					if (load_ok) begin
						// output payload, loaded with each beat of the run
						out_char_q   <= (name_len_q == '0) ? '0 : ram_rdata;
						out_cvalid_q <= (name_len_q != '0);
						out_value_q  <= run_last ? rec_value : '0;
						out_real_q   <= run_last && point_q;
						out_trunc_q  <= run_last && ovf_q;
						out_last_q   <= run_last;
						if (run_last) begin
							mode_q     <= MODE_NAME;
							name_len_q <= '0;
							ovf_q      <= 1'b0;
							int_q      <= '0;
							frac_q     <= '0;
							fdig_q     <= '0;
							point_q    <= 1'b0;
							state_q    <= ST_IN;
						end else begin
							rd_idx_q <= rd_idx_q + 1'b1;
							state_q  <= ST_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IN;
				end
			endcase
		end
	end

	assign result_valid    = out_valid_q;
	assign name_char       = out_char_q;
	assign name_char_valid = out_cvalid_q;
	assign parsed_value    = out_value_q;
	assign is_real         = out_real_q;
	assign name_truncated  = out_trunc_q;
	assign last            = out_last_q;

	// divider finishes only while the sequencer waits for it
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider done outside divide wait");

	// stored name never exceeds the ram
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		name_len_q <= LW'(NAME_DEPTH))
		else $error("name length beyond ram depth");

	// a dropped character means the ram is full
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (name_len_q == LW'(NAME_DEPTH)))
		else $error("overflow flagged with room left");

	// readback stays inside the written entries
	a_rd_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_WR) && (name_len_q != '0)) |-> (rd_idx_q < name_len_q))
		else $error("name read beyond stored length");

	// final beat of a run clears the record and reopens the input
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_WR) && load_ok && run_last)
		|=> ((state_q == ST_IN) && (name_len_q == '0) && out_valid_q && out_last_q))
		else $error("record not closed after last beat");

endmodule

// ===== rtl/nvrp_ram.sv =====
// generic simple dual-port ram with registered read
module nvrp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/nvrp_frac_div.sv =====
// restoring divider, one quotient bit per cycle, for the fixed point fraction
module nvrp_frac_div #(
	parameter int DIV_W = 27,
	parameter int Q_W   = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DIV_W-1:0] divisor,
	output logic             done,
	output logic [Q_W-1:0]   quotient
);

	localparam int RW = DIV_W + 1;
	localparam int CW = $clog2(Q_W + 1);

	logic [RW-1:0]    rem_q;
	logic [DIV_W-1:0] dsr_q;
	logic [Q_W-1:0]   quo_q;
	logic [CW-1:0]    cnt_q;
	logic             done_q;
	logic [RW-1:0]    shifted;
	logic             fits;

	assign shifted = {rem_q[RW-2:0], 1'b0};
	assign fits    = (shifted >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(Q_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, dividend};
			dsr_q <= divisor;
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? (shifted - {1'b0, dsr_q}) : shifted;
			quo_q <= {quo_q[Q_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
